// ===== design/fsla_pkg.sv =====
// Shared types and codes for the fixed-slot free-list allocator.
package fsla_pkg;

  // Fixed field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned BYTES_W  = 12;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SUM_W    = 20;
  localparam int unsigned FRESH_W  = 9;
  localparam int unsigned LINK_W   = HANDLE_W + 1;
  // Padded slot size: header (<= 16) plus object (<= 4095) rounded to <= 256
  localparam int unsigned PAD_W    = 13;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REALLOC = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_TOO_LARGE = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NONE      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_DBL_FREE  = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic                has_handle;
    logic [HANDLE_W-1:0] handle;
    logic [BYTES_W-1:0]  req_bytes;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                out_valid;
    logic [HANDLE_W-1:0] out_handle;
    logic [SUM_W-1:0]    allocated_total;
    logic [SUM_W-1:0]    wasted_total;
  } rsp_t;

  // Decoded operation
  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_RESIZE,
    OP_NONE
  } op_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

// ===== design/fsla_pad.sv =====
// Object size register and padded slot size calculation.
module fsla_pad import fsla_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 4,
  parameter int unsigned ALIGN_BYTES  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [BYTES_W-1:0] cfg_wdata,
  output logic [PAD_W-1:0]   padded,
  output logic               busy
);

  // Reciprocal of the alignment, exact for raw sizes below 2^PAD_W
  localparam int unsigned SHIFT  = PAD_W + 8;
  localparam int unsigned RECIP  = ((1 << SHIFT) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int unsigned PROD_W = PAD_W + SHIFT + 1;
  localparam logic [BYTES_W-1:0] OBJ_RESET = 12'd12;

  logic [BYTES_W-1:0] object_bytes;
  logic [BYTES_W-1:0] obj_eff;
  logic [PAD_W-1:0]   raw;
  logic [PROD_W-1:0]  quot_prod;
  logic [PAD_W-1:0]   quot;
  logic [PAD_W+8:0]   scaled;
  logic [1:0]         settle;
  logic [1:0]         settle_next;

  // Hold the object size register
  always_ff @(posedge clk) begin
    if (rst) begin
      object_bytes <= OBJ_RESET;
    end else if (cfg_we) begin
      object_bytes <= cfg_wdata;
    end
  end

  // Stage one: header plus size, divided by the alignment
  always_comb begin
    obj_eff   = (object_bytes == '0) ? BYTES_W'(1) : object_bytes;
    raw       = PAD_W'(HEADER_BYTES) + PAD_W'(obj_eff) + PAD_W'(ALIGN_BYTES - 1);
    quot_prod = PROD_W'(raw) * PROD_W'(RECIP);
  end

  always_ff @(posedge clk) begin
    quot <= quot_prod[SHIFT +: PAD_W];
  end

  // Stage two: scale back up to bytes
  assign scaled = (PAD_W + 9)'(quot) * (PAD_W + 9)'(ALIGN_BYTES);

  always_ff @(posedge clk) begin
    padded <= scaled[PAD_W-1:0];
  end

  // Count down while the two stages refill after reset or a write
  always_comb begin
    if (cfg_we) begin
      settle_next = 2'd2;
    end else if (settle != 2'd0) begin
      settle_next = settle - 2'd1;
    end else begin
      settle_next = settle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= 2'd2;
    end else begin
      settle <= settle_next;
    end
  end

  assign busy = (settle != 2'd0);

endmodule

// ===== design/fsla_ram.sv =====
// Single-port-write, single-port-read synchronous memory with registered read.
module fsla_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned WIDTH  = 12,
  parameter int unsigned ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/fixed_slot_free_list_allocator.sv =====
// A command is taken in the idle state, which issues the link and size RAM reads; the update and response follow.
// No new command is taken until the last one commits, set by the read-then-write of the link and size RAMs.
// A waiting response does not block the next command's read; its update waits for the slot.
// After reset or an object size write no command is taken while the padded-size pipeline refills.
// Reset (rst, synchronous) empties the free list and clears counters and totals; RAMs are not cleared.
module fixed_slot_free_list_allocator import fsla_pkg::*; #(
  parameter int unsigned SLOTS        = 256,
  parameter int unsigned HEADER_BYTES = 4,
  parameter int unsigned ALIGN_BYTES  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [BYTES_W-1:0] cfg_wdata,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_t               rsp
);

  localparam int unsigned CAP = (SLOTS < 256) ? SLOTS : 256;
  localparam int unsigned AW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam logic [FRESH_W-1:0] CAP_F = FRESH_W'(CAP);

  state_t state;
  state_t state_next;

  logic [PAD_W-1:0] padded;
  logic             pad_busy;

  cmd_t cmd_q;
  logic accept;
  logic commit;

  logic                head_valid;
  logic                head_valid_next;
  logic [HANDLE_W-1:0] head_slot;
  logic [HANDLE_W-1:0] head_slot_next;
  logic [FRESH_W-1:0]  fresh_count;
  logic [FRESH_W-1:0]  fresh_count_next;
  logic [SUM_W-1:0]    allocated_sum;
  logic [SUM_W-1:0]    allocated_sum_next;
  logic [SUM_W-1:0]    wasted_sum;
  logic [SUM_W-1:0]    wasted_sum_next;

  logic [LINK_W-1:0]   link_rd;
  logic [BYTES_W-1:0]  size_rd;
  logic                link_we;
  logic                size_we;
  logic                size_we_c;
  logic                link_we_c;
  logic [HANDLE_W-1:0] size_waddr;
  logic [BYTES_W-1:0]  size_wdata;

  op_t                 op;
  rsp_t                result;
  logic [BYTES_W-1:0]  size_one;
  logic [PAD_W-1:0]    limit;
  logic                in_range;
  logic                too_large;

  fsla_pad #(
    .HEADER_BYTES (HEADER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES)
  ) u_pad (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .padded    (padded),
    .busy      (pad_busy)
  );

  fsla_ram #(
    .DEPTH  (CAP),
    .WIDTH  (LINK_W),
    .ADDR_W (AW)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (cmd_q.handle[AW-1:0]),
    .wdata ({head_valid, head_slot}),
    .re    (accept),
    .raddr (head_slot[AW-1:0]),
    .rdata (link_rd)
  );

  fsla_ram #(
    .DEPTH  (CAP),
    .WIDTH  (BYTES_W),
    .ADDR_W (AW)
  ) u_size_ram (
    .clk   (clk),
    .we    (size_we),
    .waddr (size_waddr[AW-1:0]),
    .wdata (size_wdata),
    .re    (accept),
    .raddr (cmd.handle[AW-1:0]),
    .rdata (size_rd)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and update strobes
  always_comb begin
    cmd_ready = (state == ST_IDLE) && !pad_busy;
    accept    = cmd_valid && cmd_ready;
    commit    = (state == ST_EXEC) && (!rsp_valid || rsp_ready);
    link_we   = commit && link_we_c;
    size_we   = commit && size_we_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the command as its reads are issued
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
  end

  // Decode the operation
  always_comb begin
    case (cmd_q.func)
      FUNC_ALLOC: op = OP_ALLOC;
      FUNC_FREE:  op = OP_FREE;
      FUNC_REALLOC: begin
        if (!cmd_q.has_handle) begin
          op = OP_ALLOC;
        end else if (cmd_q.req_bytes == '0) begin
          op = OP_FREE;
        end else begin
          op = OP_RESIZE;
        end
      end
      default: op = OP_NONE;
    endcase
  end

  // Work out the result and the state update from the read data
  always_comb begin
    size_one  = (cmd_q.req_bytes == '0) ? BYTES_W'(1) : cmd_q.req_bytes;
    limit     = padded - PAD_W'(HEADER_BYTES);
    in_range  = ({1'b0, cmd_q.handle} < CAP_F);
    too_large = ({1'b0, size_one} > limit);

    head_valid_next    = head_valid;
    head_slot_next     = head_slot;
    fresh_count_next   = fresh_count;
    allocated_sum_next = allocated_sum;
    wasted_sum_next    = wasted_sum;
    link_we_c          = 1'b0;
    size_we_c          = 1'b0;
    size_waddr         = cmd_q.handle;
    size_wdata         = size_one;
    result.status      = STAT_NONE;
    result.out_valid   = 1'b0;
    result.out_handle  = '0;

    case (op)
      OP_ALLOC: begin
        if (too_large) begin
          result.status = STAT_TOO_LARGE;
        end else if (head_valid || (fresh_count < CAP_F)) begin
          // Pop the free list, else hand out the next fresh slot
          if (head_valid) begin
            size_waddr      = head_slot;
            head_valid_next = link_rd[LINK_W-1];
            head_slot_next  = link_rd[HANDLE_W-1:0];
          end else begin
            size_waddr       = fresh_count[HANDLE_W-1:0];
            fresh_count_next = fresh_count + FRESH_W'(1);
          end
          size_we_c          = 1'b1;
          allocated_sum_next = allocated_sum + SUM_W'(size_one);
          wasted_sum_next    = wasted_sum + (SUM_W'(padded) - SUM_W'(size_one));
          result.status      = STAT_OK;
          result.out_valid   = 1'b1;
          result.out_handle  = size_waddr;
        end else begin
          result.status = STAT_EXHAUSTED;
        end
      end
      OP_FREE: begin
        if (!cmd_q.has_handle || !in_range) begin
          result.status = STAT_NONE;
        end else if (head_valid && (cmd_q.handle == head_slot)) begin
          result.status = STAT_DBL_FREE;
        end else begin
          // Push the slot onto the free list
          link_we_c          = 1'b1;
          head_valid_next    = 1'b1;
          head_slot_next     = cmd_q.handle;
          allocated_sum_next = allocated_sum - SUM_W'(size_rd);
          wasted_sum_next    = wasted_sum - (SUM_W'(padded) - SUM_W'(size_rd));
          result.status      = STAT_NONE;
        end
      end
      OP_RESIZE: begin
        if (!in_range) begin
          result.status = STAT_NONE;
        end else if (size_rd == cmd_q.req_bytes) begin
          result.status     = STAT_OK;
          result.out_valid  = 1'b1;
          result.out_handle = cmd_q.handle;
        end else if ({1'b0, cmd_q.req_bytes} > limit) begin
          result.status = STAT_TOO_LARGE;
        end else begin
          size_we_c          = 1'b1;
          size_wdata         = cmd_q.req_bytes;
          allocated_sum_next = allocated_sum - SUM_W'(size_rd) + SUM_W'(cmd_q.req_bytes);
          wasted_sum_next    = wasted_sum + SUM_W'(size_rd) - SUM_W'(cmd_q.req_bytes);
          result.status      = STAT_OK;
          result.out_valid   = 1'b1;
          result.out_handle  = cmd_q.handle;
        end
      end
      default: begin
        result.status = STAT_NONE;
      end
    endcase

    result.allocated_total = allocated_sum_next;
    result.wasted_total    = wasted_sum_next;
  end

  // Advance the list head, fresh counter and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid    <= 1'b0;
      head_slot     <= '0;
      fresh_count   <= '0;
      allocated_sum <= '0;
      wasted_sum    <= '0;
    end else if (commit) begin
      head_valid    <= head_valid_next;
      head_slot     <= head_slot_next;
      fresh_count   <= fresh_count_next;
      allocated_sum <= allocated_sum_next;
      wasted_sum    <= wasted_sum_next;
    end
  end

  // Hold the response until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp <= result;
    end
  end

  // Checks
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("command taken while another is in flight");

  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !cmd_ready)
    else $error("command taken before padded size settled");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh_count <= CAP_F)
    else $error("fresh slot count beyond capacity");

  a_ok_has_handle: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == STAT_OK)) |-> rsp.out_valid)
    else $error("success without a returned slot");

  a_null_handle: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.out_valid) |-> (rsp.out_handle == '0))
    else $error("nonzero handle on a response without a slot");

endmodule

// ===== bench/fsla_rsp_checker.sv =====
// Response checker for the fixed-slot free-list allocator: predicts each response and compares.
module fsla_rsp_checker import fsla_pkg::*; #(
  parameter int SLOTS        = 256,
  parameter int HEADER_BYTES = 4,
  parameter int ALIGN_BYTES  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [BYTES_W-1:0] cfg_wdata,
  input  logic               cmd_valid,
  input  logic               cmd_ready,
  input  cmd_t               cmd,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  rsp_t               rsp,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = (SLOTS < 256) ? SLOTS : 256;

  // Shadow copy of the allocator state
  logic [BYTES_W-1:0]  obj_cfg;
  logic                head_ok;
  logic [HANDLE_W-1:0] head_idx;
  logic [FRESH_W-1:0]  fresh_cnt;
  logic [LINK_W-1:0]   link_mem [256];
  logic [BYTES_W-1:0]  size_mem [256];
  logic [SUM_W-1:0]    alloc_sum;
  logic [SUM_W-1:0]    waste_sum;

  rsp_t rsp_due_q[$];
  rsp_t want;

  // Padded slot size for the current object size
  function automatic int pad_bytes();
    int obj;
    obj = (obj_cfg == '0) ? 1 : int'(obj_cfg);
    return ((HEADER_BYTES + obj + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  endfunction

  // Build a response from a status and the running totals
  function automatic rsp_t rsp_pack(logic [STATUS_W-1:0] st, logic ok,
                                    logic [HANDLE_W-1:0] slot);
    rsp_t r;
    r.status          = st;
    r.out_valid       = ok;
    r.out_handle      = ok ? slot : '0;
    r.allocated_total = alloc_sum;
    r.wasted_total    = waste_sum;
    return r;
  endfunction

  // Take a slot: the head of the freed list first, else a fresh one
  function automatic rsp_t slot_take(logic [BYTES_W-1:0] req);
    int                  sz;
    int                  pad;
    logic [HANDLE_W-1:0] slot;
    sz  = (req == '0) ? 1 : int'(req);
    pad = pad_bytes();
    if (sz > pad - HEADER_BYTES) return rsp_pack(STAT_TOO_LARGE, 1'b0, '0);
    if (head_ok) begin
      slot     = head_idx;
      head_ok  = link_mem[slot][HANDLE_W];
      head_idx = link_mem[slot][HANDLE_W-1:0];
    end else if (int'(fresh_cnt) < CAPACITY) begin
      slot      = fresh_cnt[HANDLE_W-1:0];
      fresh_cnt = fresh_cnt + FRESH_W'(1);
    end else begin
      return rsp_pack(STAT_EXHAUSTED, 1'b0, '0);
    end
    size_mem[slot] = BYTES_W'(sz);
    alloc_sum = SUM_W'(int'(alloc_sum) + sz);
    waste_sum = SUM_W'(int'(waste_sum) + pad - sz);
    return rsp_pack(STAT_OK, 1'b1, slot);
  endfunction

  // Push a slot back onto the freed list
  function automatic rsp_t slot_give(logic has, logic [HANDLE_W-1:0] h);
    int sz;
    int pad;
    if (!has || int'(h) >= CAPACITY) return rsp_pack(STAT_NONE, 1'b0, '0);
    if (head_ok && h == head_idx) return rsp_pack(STAT_DBL_FREE, 1'b0, '0);
    sz  = int'(size_mem[h]);
    pad = pad_bytes();
    link_mem[h] = {head_ok, head_idx};
    head_idx    = h;
    head_ok     = 1'b1;
    alloc_sum = SUM_W'(int'(alloc_sum) - sz);
    waste_sum = SUM_W'(int'(waste_sum) - (pad - sz));
    return rsp_pack(STAT_NONE, 1'b0, '0);
  endfunction

  // Work out the response to one command and update the shadow state
  function automatic rsp_t predict_rsp(cmd_t c);
    int old;
    int req;
    req = int'(c.req_bytes);
    case (c.func)
      FUNC_ALLOC: return slot_take(c.req_bytes);
      FUNC_FREE:  return slot_give(c.has_handle, c.handle);
      FUNC_REALLOC: begin
        if (!c.has_handle) return slot_take(c.req_bytes);
        if (req == 0) return slot_give(c.has_handle, c.handle);
        if (int'(c.handle) >= CAPACITY) return rsp_pack(STAT_NONE, 1'b0, '0);
        old = int'(size_mem[c.handle]);
        if (old == req) return rsp_pack(STAT_OK, 1'b1, c.handle);
        if (req > pad_bytes() - HEADER_BYTES) return rsp_pack(STAT_TOO_LARGE, 1'b0, '0);
        // Resize in place; padding absorbs the difference
        size_mem[c.handle] = c.req_bytes;
        alloc_sum = SUM_W'(int'(alloc_sum) - old + req);
        waste_sum = SUM_W'(int'(waste_sum) + old - req);
        return rsp_pack(STAT_OK, 1'b1, c.handle);
      end
      default: return rsp_pack(STAT_NONE, 1'b0, '0);
    endcase
  endfunction

  // Track configuration, predict on each command, compare on each response
  always @(posedge clk) begin
    if (rst) begin
      obj_cfg   = BYTES_W'(12);
      head_ok   = 1'b0;
      head_idx  = '0;
      fresh_cnt = '0;
      alloc_sum = '0;
      waste_sum = '0;
      rsp_due_q.delete();
    end else begin
      if (cfg_we) obj_cfg = cfg_wdata;
      if (cmd_valid && cmd_ready) rsp_due_q.push_back(predict_rsp(cmd));
      if (rsp_valid && rsp_ready) begin
        if (rsp_due_q.size() == 0) begin
          errors++;
          $error("unexpected response transaction: status %0d handle %0d",
                 rsp.status, rsp.out_handle);
        end else begin
          want = rsp_due_q.pop_front();
          if (rsp.status !== want.status) begin
            errors++;
            $error("status: expected %0d, got %0d", want.status, rsp.status);
          end
          if (rsp.out_valid !== want.out_valid) begin
            errors++;
            $error("out_valid: expected %0d, got %0d", want.out_valid, rsp.out_valid);
          end
          if (rsp.out_handle !== want.out_handle) begin
            errors++;
            $error("out_handle: expected %0d, got %0d", want.out_handle, rsp.out_handle);
          end
          if (rsp.allocated_total !== want.allocated_total) begin
            errors++;
            $error("allocated_total: expected %0d, got %0d",
                   want.allocated_total, rsp.allocated_total);
          end
          if (rsp.wasted_total !== want.wasted_total) begin
            errors++;
            $error("wasted_total: expected %0d, got %0d",
                   want.wasted_total, rsp.wasted_total);
          end
        end
      end
    end
    pending = rsp_due_q.size();
  end

endmodule

// ===== bench/fixed_slot_free_list_allocator_tb.sv =====
// Testbench top for the fixed-slot free-list allocator: stimulus, idling and verdict.
module fixed_slot_free_list_allocator_tb import fsla_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = 256;
  localparam int HEADER_BYTES = 4;
  localparam int ALIGN_BYTES  = 16;

  // Function code with no operation behind it
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [BYTES_W-1:0] cfg_wdata = '0;
  logic               cmd_valid = 1'b0;
  logic               cmd_ready;
  cmd_t               cmd       = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  rsp_t               rsp;

  int                  errs;
  int                  pend;
  int                  handed     = 0;
  logic [HANDLE_W-1:0] last_freed = '0;
  bit                  freed_any  = 1'b0;
  bit                  cmd_busy   = 1'b1;

  fixed_slot_free_list_allocator #(
    .SLOTS(SLOTS), .HEADER_BYTES(HEADER_BYTES), .ALIGN_BYTES(ALIGN_BYTES)
  ) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  fsla_rsp_checker #(
    .SLOTS(SLOTS), .HEADER_BYTES(HEADER_BYTES), .ALIGN_BYTES(ALIGN_BYTES)
  ) checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .errors(errs), .pending(pend)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Slots are handed out fresh in order, so every handle below this bound has a size recorded
  always @(posedge clk) begin
    if (rsp_valid && rsp_ready && rsp.out_valid && int'(rsp.out_handle) >= handed)
      handed <= int'(rsp.out_handle) + 1;
  end

  function automatic cmd_t mk(logic [FUNC_W-1:0] f, logic has, int h, int req);
    cmd_t c;
    c.func       = f;
    c.has_handle = has;
    c.handle     = HANDLE_W'(h);
    c.req_bytes  = BYTES_W'(req);
    return c;
  endfunction

  // Present one command transaction after a random gap and hold it until taken
  task automatic issue_cmd(input cmd_t c);
    int gap;
    bit took;
    if ($urandom_range(0, 63) == 0) cmd_busy = !cmd_busy;
    gap = cmd_busy ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do begin
      @(negedge clk);
      took = cmd_ready;
      @(posedge clk);
    end while (!took);
  endtask

  // Drain, write a new object size while idle, then run random commands
  task automatic run_phase(input int obj, input int n, input int alloc_pct);
    int   cap;
    int   op;
    int   roll;
    cmd_t c;
    do @(negedge clk); while (pend != 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= BYTES_W'(obj);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cap = ((HEADER_BYTES + ((obj == 0) ? 1 : obj) + ALIGN_BYTES - 1) / ALIGN_BYTES)
          * ALIGN_BYTES - HEADER_BYTES;
    for (int i = 0; i < n; i++) begin
      c.has_handle = 1'($urandom_range(0, 1));
      c.handle     = HANDLE_W'($urandom_range(0, 255));
      // Mostly sizes that fit, some on the boundary, a few anywhere
      roll = $urandom_range(0, 9);
      if (roll == 0) c.req_bytes = BYTES_W'($urandom_range(0, 4095));
      else if (roll == 1) c.req_bytes = BYTES_W'(cap + $urandom_range(0, 1));
      else c.req_bytes = BYTES_W'($urandom_range(0, cap));
      if ($urandom_range(0, 99) < alloc_pct) begin
        c.func = FUNC_ALLOC;
      end else begin
        op = $urandom_range(0, 19);
        c.func = (op < 9) ? FUNC_FREE : (op < 18) ? FUNC_REALLOC : FUNC_UNUSED;
      end
      // Only name slots that have been handed out; favor the last freed one
      if (c.func == FUNC_FREE || c.func == FUNC_REALLOC) begin
        c.has_handle = ($urandom_range(0, 9) != 0) && (handed > 0);
        if (c.has_handle) begin
          if (freed_any && $urandom_range(0, 3) == 0) c.handle = last_freed;
          else c.handle = HANDLE_W'($urandom_range(0, handed - 1));
          if (c.func == FUNC_FREE || c.req_bytes == '0) begin
            last_freed = c.handle;
            freed_any  = 1'b1;
          end
        end
      end
      issue_cmd(c);
    end
    cmd_valid <= 1'b0;
  endtask

  // Response side: random stalls before each transaction, with quiet stretches
  initial begin
    int stall;
    bit took;
    bit busy;
    busy = 1'b1;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) busy = !busy;
      stall = busy ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = rsp_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed sequence at the reset object size of 12 bytes
    issue_cmd(mk(FUNC_ALLOC, 1'b0, 0, 0));          // zero size becomes one
    issue_cmd(mk(FUNC_ALLOC, 1'b1, 255, 12));       // largest size that fits
    issue_cmd(mk(FUNC_ALLOC, 1'b0, 0, 13));         // one byte too large
    issue_cmd(mk(FUNC_ALLOC, 1'b1, 128, 4095));
    issue_cmd(mk(FUNC_FREE, 1'b0, 255, 4095));      // null free
    issue_cmd(mk(FUNC_FREE, 1'b1, 0, 0));
    issue_cmd(mk(FUNC_FREE, 1'b1, 0, 0));           // double free of the head
    issue_cmd(mk(FUNC_FREE, 1'b1, 1, 0));
    issue_cmd(mk(FUNC_ALLOC, 1'b0, 0, 5));          // pops slot 1
    issue_cmd(mk(FUNC_REALLOC, 1'b0, 200, 7));      // null handle allocates
    issue_cmd(mk(FUNC_REALLOC, 1'b1, 0, 0));        // zero size frees
    issue_cmd(mk(FUNC_REALLOC, 1'b1, 1, 5));        // same size
    issue_cmd(mk(FUNC_REALLOC, 1'b1, 1, 12));       // grow in place
    issue_cmd(mk(FUNC_REALLOC, 1'b1, 1, 13));       // too large, slot kept
    issue_cmd(mk(FUNC_REALLOC, 1'b1, 1, 4095));
    issue_cmd(mk(FUNC_UNUSED, 1'b1, 255, 4095));
    issue_cmd(mk(FUNC_UNUSED, 1'b0, 0, 0));
    issue_cmd(mk(FUNC_ALLOC, 1'b0, 0, 12));         // pops slot 0
    issue_cmd(mk(FUNC_ALLOC, 1'b0, 0, 1));          // fresh slot 2
    issue_cmd(mk(FUNC_FREE, 1'b1, 2, 0));
    issue_cmd(mk(FUNC_REALLOC, 1'b1, 2, 3));        // resize a freed slot
    cmd_valid <= 1'b0;

    // Random phases over several object sizes, one of them filling the pool
    run_phase(0, 300, 45);
    run_phase(4092, 550, 85);
    run_phase($urandom_range(1, 4092), 400, 40);
    run_phase(3, 300, 30);
    run_phase(12, 380, 50);

    do @(negedge clk); while (pend != 0);
    repeat (8) @(posedge clk);
    if (errs == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
